@@ hdl/wfd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wfd_pkg
// Field kind codes, widths and helper functions for the wire field decoder.
// ----------------------------------------------------------------------------
package wfd_pkg;

    localparam int unsigned KIND_W  = 3;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 4;

    typedef logic [KIND_W-1:0]  t_kind;
    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [COUNT_W-1:0] t_count;

    localparam t_kind KIND_U8       = 3'd0;
    localparam t_kind KIND_U16      = 3'd1;
    localparam t_kind KIND_U32      = 3'd2;
    localparam t_kind KIND_VARUINT  = 3'd3;
    localparam t_kind KIND_VARINT   = 3'd4;
    localparam t_kind KIND_VARFLOAT = 3'd5;

    localparam t_byte  CONT_BIT   = 8'h80;
    localparam t_byte  GROUP_MASK = 8'h7f;
    localparam t_count COUNT_MAX  = 4'd15;
    localparam t_count VARINT_MAX = 4'd5;

    // Places one byte of a little-endian fixed-width field; bytes past the
    // fourth contribute nothing.
    function automatic t_value fixed_part(input t_count idx, input t_byte b);
        t_value part;
        begin
            part = '0;
            case (idx)
                4'd0:    part = {24'd0, b};
                4'd1:    part = {16'd0, b, 8'd0};
                4'd2:    part = {8'd0, b, 16'd0};
                4'd3:    part = {b, 24'd0};
                default: part = '0;
            endcase
            fixed_part = part;
        end
    endfunction

    // Places one seven-bit group of a varint; bits above bit 31 are dropped.
    function automatic t_value varint_part(input t_count idx, input t_byte b);
        t_value grp;
        t_value part;
        begin
            grp  = {24'd0, b & GROUP_MASK};
            part = '0;
            case (idx)
                4'd0:    part = grp;
                4'd1:    part = grp << 7;
                4'd2:    part = grp << 14;
                4'd3:    part = grp << 21;
                4'd4:    part = grp << 28;
                default: part = '0;
            endcase
            varint_part = part;
        end
    endfunction

    function automatic t_value zigzag_decode(input t_value v);
        begin
            zigzag_decode = {VALUE_W{v[0]}} ^ {1'b0, v[VALUE_W-1:1]};
        end
    endfunction

    function automatic t_value byte_swap(input t_value v);
        begin
            byte_swap = {v[7:0], v[15:8], v[23:16], v[31:24]};
        end
    endfunction

endpackage
`default_nettype wire

@@ hdl/wire_field_decoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wire_field_decoder
// Byte-serial decoder for tagged u8, u16, u32, varuint, varint and varfloat
// fields, emitting one decoded word per completed field.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_valid, o_stall) carries one message byte per word,
// tagged with its field kind in i_op; the kind is only looked at on the first
// byte of a field. The output channel (o_valid, i_stall) carries one word per
// completed field: the value, the latched kind, the byte count (saturating at
// fifteen) and a flag for varints longer than five bytes.
// A byte passes an input register and then a result register, so a field's
// result is offered once its last byte has passed the input register.
// One byte is accepted in every cycle while o_stall is low; the field state
// is a single 32-bit shift-or accumulator, updated once per byte.
// When the receiver stalls, the result register holds its word and the input
// register holds one further byte; o_stall then rises until the result is
// taken. Reset, synchronous and active low, empties both registers and
// abandons any partly decoded field.
// ----------------------------------------------------------------------------
module wire_field_decoder (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire wfd_pkg::t_kind  i_op,
    input  wire wfd_pkg::t_byte  i_data_byte,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output wfd_pkg::t_value      o_value,
    output wfd_pkg::t_kind       o_field_kind,
    output wfd_pkg::t_count      o_byte_count,
    output logic                 o_overlong
);
    import wfd_pkg::*;

    logic   r_in_valid;
    t_kind  r_in_op;
    t_byte  r_in_byte;

    logic   r_in_field;
    t_value r_acc;
    t_count r_seen;
    t_kind  r_kind;

    logic   r_out_valid;
    t_value r_out_value;
    t_kind  r_out_kind;
    t_count r_out_count;
    logic   r_out_overlong;

    logic   out_free;
    logic   process;
    logic   in_take;
    t_kind  kind;
    t_value acc_base;
    t_count idx;
    t_count count;
    logic   varlen;
    logic   done;
    t_value n_acc;
    t_value value;

    assign out_free = !r_out_valid || !i_stall;
    assign process  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    always_comb begin
        kind     = r_in_field ? r_kind : r_in_op;
        acc_base = r_in_field ? r_acc : '0;
        idx      = r_in_field ? r_seen : '0;
        count    = (idx < COUNT_MAX) ? idx + 4'd1 : COUNT_MAX;
        varlen   = 1'b0;
        case (kind)
            KIND_U16: begin
                n_acc = acc_base | fixed_part(idx, r_in_byte);
                done  = (count >= 4'd2);
            end
            KIND_U32: begin
                n_acc = acc_base | fixed_part(idx, r_in_byte);
                done  = (count >= 4'd4);
            end
            KIND_VARUINT, KIND_VARINT, KIND_VARFLOAT: begin
                varlen = 1'b1;
                n_acc  = acc_base | varint_part(idx, r_in_byte);
                done   = ((r_in_byte & CONT_BIT) == 8'd0);
            end
            default: begin
                n_acc = {24'd0, r_in_byte};
                done  = 1'b1;
            end
        endcase
        case (kind)
            KIND_VARINT:   value = zigzag_decode(n_acc);
            KIND_VARFLOAT: value = byte_swap(zigzag_decode(n_acc));
            default:       value = n_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op   <= i_op;
            r_in_byte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_field <= 1'b0;
            r_acc      <= '0;
            r_seen     <= '0;
            r_kind     <= '0;
        end else if (process) begin
            r_in_field <= !done;
            r_acc      <= n_acc;
            r_seen     <= count;
            r_kind     <= kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= process && done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process && done) begin
            r_out_value    <= value;
            r_out_kind     <= kind;
            r_out_count    <= count;
            r_out_overlong <= varlen && (count > VARINT_MAX);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_value      = r_out_value;
    assign o_field_kind = r_out_kind;
    assign o_byte_count = r_out_count;
    assign o_overlong   = r_out_overlong;

    a_overlong_varint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overlong |-> (o_field_kind == KIND_VARUINT ||
            o_field_kind == KIND_VARINT || o_field_kind == KIND_VARFLOAT))
        else $error("overlong flag on a fixed-width field");

    a_u16_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_field_kind == KIND_U16 |-> o_byte_count == 4'd2)
        else $error("u16 field with wrong byte count");

    a_u32_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_field_kind == KIND_U32 |-> o_byte_count == 4'd4)
        else $error("u32 field with wrong byte count");

    a_single_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_field_kind == KIND_U8 || o_field_kind > KIND_VARFLOAT)
        |-> o_byte_count == 4'd1 && o_value[31:8] == 24'd0)
        else $error("single-byte field decoded wrongly");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

endmodule
`default_nettype wire
